>>> hdl/spw_pkg.sv
// Shared constants and types for the spiral progress pixel walker.
// No dependencies; used by spw_walker and spiral_progress_pixel_walker.
package spw_pkg;

  // Default matrix side length.
  localparam int SIDE_DEFAULT = 5;

  // Full-scale percentage; larger requests saturate here.
  localparam int PCT_FULL = 100;

  // Input command codes.
  localparam logic CMD_START    = 1'b0;
  localparam logic CMD_PROGRESS = 1'b1;

  // Output action codes.
  localparam logic ACT_TOGGLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Response from the spiral walker: coordinates are already offset to the matrix.
  typedef struct packed {
    logic       done;
    logic [2:0] column;
    logic [2:0] row;
  } walk_rsp_t;

endpackage

>>> hdl/spw_walker.sv
// Spiral walker: steps a coordinate pair along the spiral one move per cycle.
// Depends on spw_pkg for the response struct.
module spw_walker import spw_pkg::*; #(
  parameter int SIDE = SIDE_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [$clog2(SIDE*SIDE+1)-1:0]       idx,
  output walk_rsp_t                            rsp
);

  localparam int IW = $clog2(SIDE*SIDE+1);
  localparam int CW = $clog2(SIDE) + 2;

  logic                 busy;
  logic [IW-1:0]        target;
  logic [IW-1:0]        count;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] ax;
  logic signed [CW-1:0] ay;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic                 move_x;
  logic                 done;

  assign ax     = x[CW-1] ? -x : x;
  assign ay     = y[CW-1] ? -y : y;
  // Move along x when not further out on x than on y, except on the
  // positive diagonal, where the turn goes onto y.
  assign move_x = (ax <= ay) && ((x != y) || (x <= 0));
  assign done   = busy && (count == target);

  assign cx = x + $signed(CW'(SIDE / 2));
  assign cy = y + $signed(CW'(SIDE / 2));

  assign rsp.done   = done;
  assign rsp.column = cx[2:0];
  assign rsp.row    = cy[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      target <= idx;
      count  <= '0;
      x      <= '0;
      y      <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      count <= count + IW'(1);
      if (move_x) begin
        x <= (y <= 0) ? x - CW'(1) : x + CW'(1);
      end else begin
        y <= (x <= 0) ? y + CW'(1) : y - CW'(1);
      end
    end
  end

endmodule

>>> hdl/spiral_progress_pixel_walker.sv
// Top level of the spiral progress pixel walker: command handling, step
// sequencing and the output register. Depends on spw_pkg and spw_walker.
//
// The block drives a SIDE x SIDE LED matrix as a progress indicator that
// fills along a spiral from the outer corner inward. A start beat (tuser at
// the start code) clears the step count and produces two output beats: a
// clear-display action with zero coordinates, then a toggle of the centre
// pixel marked with tlast. A progress beat carries a percentage in tdata,
// saturated at 100. It first produces a centre toggle, so the centre pixel
// blinks, and then one toggle for each newly reached step up to
// SIDE*SIDE*percent/100; the count never goes down. Step n toggles the pixel
// reached by walking the spiral from the centre for SIDE*SIDE-n moves. The
// walk is done by a single stepping unit that makes one move per cycle and
// starts again from the centre for every step. Each output beat is held
// until it is taken, and the block accepts no input beat until every
// result of the previous one has been delivered.
module spiral_progress_pixel_walker import spw_pkg::*; #(
  parameter int SIDE = SIDE_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [6:0] percent, [7] zero
  input  logic       s_axis_tuser,   // [0] cmd
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [2:0] column, [5:3] row, [7:6] zero
  output logic       m_axis_tuser,   // [0] action
  output logic       m_axis_tlast    // last result of the input beat
);

  localparam int PIX = SIDE * SIDE;
  localparam int SW  = $clog2(PIX + 1);
  localparam int LW  = $clog2((PIX + 1) * PCT_FULL + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_STEP,
    ST_WALK,
    ST_SEND
  } state_t;

  state_t        state;
  state_t        after_send;
  logic          is_start;
  logic [LW-1:0] goal;
  logic [SW-1:0] steps_shown;
  logic          out_action;
  logic [2:0]    out_column;
  logic [2:0]    out_row;
  logic          out_last;
  logic          walk_start;
  logic [SW-1:0] walk_idx;
  walk_rsp_t     walk_rsp;

  logic [6:0]    pct_sat;
  logic [LW-1:0] next_scaled;
  logic          more;
  logic          in_fire;

  // A further step is due while (steps_shown + 1) * 100 <= SIDE*SIDE*percent,
  // which avoids any division by 100.
  assign pct_sat     = (s_axis_tdata[6:0] > 7'(PCT_FULL)) ? 7'(PCT_FULL) : s_axis_tdata[6:0];
  assign next_scaled = (LW'(steps_shown) + LW'(1)) * LW'(PCT_FULL);
  assign more        = !is_start && (next_scaled <= goal);
  assign in_fire     = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {2'b00, out_row, out_column};
  assign m_axis_tuser  = out_action;
  assign m_axis_tlast  = out_last;

  spw_walker #(
    .SIDE (SIDE)
  ) u_walker (
    .clk   (clk),
    .rst   (rst),
    .start (walk_start),
    .idx   (walk_idx),
    .rsp   (walk_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      after_send    <= ST_IDLE;
      steps_shown   <= '0;
      m_axis_tvalid <= 1'b0;
      walk_start    <= 1'b0;
      is_start      <= 1'b0;
    end else begin
      walk_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser == CMD_START) begin
              is_start      <= 1'b1;
              steps_shown   <= '0;
              out_action    <= ACT_CLEAR;
              out_column    <= '0;
              out_row       <= '0;
              out_last      <= 1'b0;
              m_axis_tvalid <= 1'b1;
              after_send    <= ST_CENTRE;
              state         <= ST_SEND;
            end else begin
              is_start <= 1'b0;
              goal     <= LW'(PIX) * LW'(pct_sat);
              state    <= ST_CENTRE;
            end
          end
        end
        ST_CENTRE: begin
          out_action    <= ACT_TOGGLE;
          out_column    <= 3'(SIDE / 2);
          out_row       <= 3'(SIDE / 2);
          out_last      <= !more;
          m_axis_tvalid <= 1'b1;
          after_send    <= more ? ST_STEP : ST_IDLE;
          state         <= ST_SEND;
        end
        ST_STEP: begin
          steps_shown <= steps_shown + SW'(1);
          walk_idx    <= SW'(PIX) - (steps_shown + SW'(1));
          walk_start  <= 1'b1;
          state       <= ST_WALK;
        end
        ST_WALK: begin
          if (!walk_start && walk_rsp.done) begin
            out_action    <= ACT_TOGGLE;
            out_column    <= walk_rsp.column;
            out_row       <= walk_rsp.row;
            out_last      <= !more;
            m_axis_tvalid <= 1'b1;
            after_send    <= more ? ST_STEP : ST_IDLE;
            state         <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state         <= after_send;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_steps_bounded: assert property (@(posedge clk) disable iff (rst)
    steps_shown <= SW'(PIX))
    else $error("step count ran past the matrix size");

  a_ready_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input accepted while a result is still pending");

  a_clear_shape: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ACT_CLEAR)) |-> (!m_axis_tlast && (m_axis_tdata == 8'd0)))
    else $error("clear action carries coordinates or end marker");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (s_axis_tuser == CMD_START)) |=> (steps_shown == '0))
    else $error("start command did not clear the step count");
`endif

endmodule
